// ===== rtl/core/lcsd_pkg.sv =====
// shared types and codes for the line diff block
package lcsd_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_LOAD_OLD = 3'd1,
    OP_LOAD_NEW = 3'd2,
    OP_COMPUTE  = 3'd3,
    OP_FETCH    = 3'd4
  } lcsd_op_e;

  typedef enum logic [1:0] {
    KIND_KEEP   = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_INSERT = 2'd2,
    KIND_DONE   = 2'd3
  } lcsd_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_INIT,
    ST_FILL_ROW,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_WALK_RD1,
    ST_WALK_RD2,
    ST_WALK_EMIT
  } lcsd_state_e;

  typedef struct packed {
    logic clear;
    logic load_old;
    logic load_new;
    logic fill_init;
    logic fill_row;
    logic fill_rd;
    logic fill_wr;
    logic walk_rd1;
    logic walk_rd2;
    logic walk_emit;
  } lcsd_cmd_t;

  typedef struct packed {
    logic col_last;
    logic fill_last;
    logic out_busy;
  } lcsd_status_t;

endpackage

// ===== rtl/core/lcsd_ram.sv =====
// generic memory with one write port and one registered read port
module lcsd_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lcsd_ctrl.sv =====
// sequencer for loads, table fill and edit walk
module lcsd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [2:0]            opcode_i,
  input  lcsd_pkg::lcsd_status_t status_i,
  output logic                  in_ready_o,
  output lcsd_pkg::lcsd_cmd_t   cmd_o
);
  import lcsd_pkg::*;

  lcsd_state_e state_q, state_d;
  logic        accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_COMPUTE: state_d = ST_FILL_INIT;
            OP_FETCH:   state_d = ST_WALK_RD1;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL_INIT: state_d = ST_FILL_ROW;
      ST_FILL_ROW:  state_d = ST_FILL_RD;
      ST_FILL_RD:   state_d = ST_FILL_WR;
      ST_FILL_WR: begin
        if (status_i.fill_last) begin
          state_d = ST_IDLE;
        end else if (status_i.col_last) begin
          state_d = ST_FILL_ROW;
        end else begin
          state_d = ST_FILL_RD;
        end
      end
      ST_WALK_RD1:  state_d = ST_WALK_RD2;
      ST_WALK_RD2:  state_d = ST_WALK_EMIT;
      ST_WALK_EMIT: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_CLEAR:    cmd_o.clear    = 1'b1;
            OP_LOAD_OLD: cmd_o.load_old = 1'b1;
            OP_LOAD_NEW: cmd_o.load_new = 1'b1;
            default:     cmd_o          = '0;
          endcase
        end
      end
      ST_FILL_INIT: cmd_o.fill_init = 1'b1;
      ST_FILL_ROW:  cmd_o.fill_row  = 1'b1;
      ST_FILL_RD:   cmd_o.fill_rd   = 1'b1;
      ST_FILL_WR:   cmd_o.fill_wr   = 1'b1;
      ST_WALK_RD1:  cmd_o.walk_rd1  = 1'b1;
      ST_WALK_RD2:  cmd_o.walk_rd2  = 1'b1;
      ST_WALK_EMIT: cmd_o.walk_emit = !status_i.out_busy;
      default:      cmd_o           = '0;
    endcase
  end

endmodule

// ===== rtl/core/lcsd_dp.sv =====
// line stores, lcs table, fill and walk datapath, result register
module lcsd_dp #(
  parameter int unsigned MAX_LINES  = 256,
  parameter int unsigned TOKEN_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lcsd_pkg::lcsd_cmd_t    cmd_i,
  input  logic [31:0]            line_token_i,
  input  logic                   out_ready_i,
  output lcsd_pkg::lcsd_status_t status_o,
  output logic                   out_valid_o,
  output logic [1:0]             edit_kind_o,
  output logic [7:0]             line_index_o,
  output logic [31:0]            edit_token_o,
  output logic                   overflowed_o
);
  import lcsd_pkg::*;

  localparam int unsigned Side     = MAX_LINES + 1;
  localparam int unsigned CntW     = $clog2(MAX_LINES + 1);
  localparam int unsigned IdxW     = $clog2(MAX_LINES);
  localparam int unsigned TabDepth = Side * Side;
  localparam int unsigned TabW     = $clog2(TabDepth);
  localparam int unsigned StoreW   = (TOKEN_BITS < 32) ? TOKEN_BITS : 32;
  localparam logic [CntW-1:0] Full  = CntW'(MAX_LINES);
  localparam logic [TabW-1:0] SideA = TabW'(Side);

  // control registers
  logic [CntW-1:0] old_cnt_q, new_cnt_q;
  logic            ovf_q;
  logic [CntW-1:0] wi_q, wj_q;
  logic [TabW-1:0] waddr_q;
  logic [CntW-1:0] fi_q, fj_q;
  logic            out_valid_q;

  // payload registers
  logic [TabW-1:0]   faddr_q;
  logic [CntW-1:0]   right_q, diag_q, down_q;
  lcsd_kind_e        kind_q;
  logic [7:0]        index_q;
  logic [31:0]       token_q;
  logic              ovf_out_q;

  // memory ports
  logic              old_we, new_we, old_re, new_re, tab_re;
  logic [IdxW-1:0]   old_raddr, new_raddr;
  logic [StoreW-1:0] old_rdata, new_rdata, tok_in;
  logic [TabW-1:0]   tab_raddr;
  logic [CntW-1:0]   tab_rdata;

  // fill and walk logic
  logic              old_full, new_full, tok_eq, fill_bnd;
  logic [CntW-1:0]   fill_max, fill_v;
  logic              has_old, has_new;
  lcsd_kind_e        emit_kind;
  logic [CntW-1:0]   emit_idx;
  logic [StoreW-1:0] emit_tok;

  assign tok_in   = line_token_i[StoreW-1:0];
  assign old_full = (old_cnt_q == Full);
  assign new_full = (new_cnt_q == Full);
  assign old_we   = cmd_i.load_old && !old_full;
  assign new_we   = cmd_i.load_new && !new_full;

  assign old_re    = cmd_i.fill_row || cmd_i.walk_rd1;
  assign old_raddr = cmd_i.fill_row ? fi_q[IdxW-1:0] : wi_q[IdxW-1:0];
  assign new_re    = cmd_i.fill_rd || cmd_i.walk_rd1;
  assign new_raddr = cmd_i.fill_rd ? fj_q[IdxW-1:0] : wj_q[IdxW-1:0];
  assign tab_re    = cmd_i.fill_rd || cmd_i.walk_rd1 || cmd_i.walk_rd2;

  always_comb begin
    tab_raddr = faddr_q + SideA;
    if (cmd_i.walk_rd1) begin
      tab_raddr = waddr_q + SideA;
    end else if (cmd_i.walk_rd2) begin
      tab_raddr = waddr_q + TabW'(1);
    end
  end

  lcsd_ram #(
    .WIDTH (StoreW),
    .DEPTH (MAX_LINES)
  ) u_old_ram (
    .clk_i   (clk_i),
    .we_i    (old_we),
    .waddr_i (old_cnt_q[IdxW-1:0]),
    .wdata_i (tok_in),
    .re_i    (old_re),
    .raddr_i (old_raddr),
    .rdata_o (old_rdata)
  );

  lcsd_ram #(
    .WIDTH (StoreW),
    .DEPTH (MAX_LINES)
  ) u_new_ram (
    .clk_i   (clk_i),
    .we_i    (new_we),
    .waddr_i (new_cnt_q[IdxW-1:0]),
    .wdata_i (tok_in),
    .re_i    (new_re),
    .raddr_i (new_raddr),
    .rdata_o (new_rdata)
  );

  lcsd_ram #(
    .WIDTH (CntW),
    .DEPTH (TabDepth)
  ) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fill_wr),
    .waddr_i (faddr_q),
    .wdata_i (fill_v),
    .re_i    (tab_re),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  // one table cell: down from the ram, right and diagonal from registers
  assign tok_eq   = (old_rdata == new_rdata);
  assign fill_bnd = (fi_q == old_cnt_q) || (fj_q == new_cnt_q);
  assign fill_max = (tab_rdata > right_q) ? tab_rdata : right_q;
  assign fill_v   = fill_bnd ? '0 : (tok_eq ? diag_q + CntW'(1) : fill_max);

  // walk decision, right neighbor sits on the table read port
  assign has_old = (wi_q < old_cnt_q);
  assign has_new = (wj_q < new_cnt_q);

  always_comb begin
    if (has_old && has_new) begin
      if (tok_eq) begin
        emit_kind = KIND_KEEP;
      end else if (down_q >= tab_rdata) begin
        emit_kind = KIND_DELETE;
      end else begin
        emit_kind = KIND_INSERT;
      end
    end else if (has_old) begin
      emit_kind = KIND_DELETE;
    end else if (has_new) begin
      emit_kind = KIND_INSERT;
    end else begin
      emit_kind = KIND_DONE;
    end
  end

  always_comb begin
    case (emit_kind)
      KIND_KEEP, KIND_DELETE: begin
        emit_idx = wi_q;
        emit_tok = old_rdata;
      end
      KIND_INSERT: begin
        emit_idx = wj_q;
        emit_tok = new_rdata;
      end
      default: begin
        emit_idx = '0;
        emit_tok = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_cnt_q   <= '0;
      new_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      wi_q        <= '0;
      wj_q        <= '0;
      waddr_q     <= '0;
      fi_q        <= '0;
      fj_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        old_cnt_q <= '0;
        new_cnt_q <= '0;
        ovf_q     <= 1'b0;
        wi_q      <= '0;
        wj_q      <= '0;
        waddr_q   <= '0;
      end
      if (cmd_i.load_old) begin
        if (old_full) begin
          ovf_q <= 1'b1;
        end else begin
          old_cnt_q <= old_cnt_q + CntW'(1);
        end
      end
      if (cmd_i.load_new) begin
        if (new_full) begin
          ovf_q <= 1'b1;
        end else begin
          new_cnt_q <= new_cnt_q + CntW'(1);
        end
      end
      if (cmd_i.fill_init) begin
        fi_q    <= old_cnt_q;
        fj_q    <= new_cnt_q;
        wi_q    <= '0;
        wj_q    <= '0;
        waddr_q <= '0;
      end
      if (cmd_i.fill_wr) begin
        if (fj_q == '0) begin
          if (fi_q != '0) begin
            fi_q <= fi_q - CntW'(1);
            fj_q <= new_cnt_q;
          end
        end else begin
          fj_q <= fj_q - CntW'(1);
        end
      end
      if (cmd_i.walk_emit) begin
        case (emit_kind)
          KIND_KEEP: begin
            wi_q    <= wi_q + CntW'(1);
            wj_q    <= wj_q + CntW'(1);
            waddr_q <= waddr_q + SideA + TabW'(1);
          end
          KIND_DELETE: begin
            wi_q    <= wi_q + CntW'(1);
            waddr_q <= waddr_q + SideA;
          end
          KIND_INSERT: begin
            wj_q    <= wj_q + CntW'(1);
            waddr_q <= waddr_q + TabW'(1);
          end
          default: begin
            wi_q <= wi_q;
          end
        endcase
      end
      if (cmd_i.walk_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_init) begin
      faddr_q <= TabW'(old_cnt_q) * SideA + TabW'(new_cnt_q);
    end
    if (cmd_i.fill_wr) begin
      right_q <= fill_v;
      diag_q  <= fill_bnd ? '0 : tab_rdata;
      if (fj_q == '0) begin
        faddr_q <= faddr_q - SideA + TabW'(new_cnt_q);
      end else begin
        faddr_q <= faddr_q - TabW'(1);
      end
    end
    if (cmd_i.walk_rd2) begin
      down_q <= tab_rdata;
    end
    if (cmd_i.walk_emit) begin
      kind_q    <= emit_kind;
      index_q   <= 8'(emit_idx);
      token_q   <= 32'(emit_tok);
      ovf_out_q <= ovf_q;
    end
  end

  assign status_o.col_last  = (fj_q == '0);
  assign status_o.fill_last = (fi_q == '0) && (fj_q == '0);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign edit_kind_o  = kind_q;
  assign line_index_o = index_q;
  assign edit_token_o = token_q;
  assign overflowed_o = ovf_out_q;

endmodule

// ===== rtl/core/lcs_line_diff.sv =====
// top level of the lcs line diff block
// clear and load requests complete on acceptance and leave the block ready; a fetch reads the
// table twice and then emits, and its result appears as the block becomes ready again, so
// fetches do not overlap, and the emit waits while the previous result waits for the receiver
// compute holds off requests while it fills the table row by row, a read and a write state
// per table cell through the single read port of the table memory
// reset clears counts, walk position, overflow flag and result valid; stores, table and result fields keep
module lcs_line_diff #(
  parameter int unsigned MAX_LINES  = 256,
  parameter int unsigned TOKEN_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] line_token_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  edit_kind_o,
  output logic [7:0]  line_index_o,
  output logic [31:0] edit_token_o,
  output logic        overflowed_o
);
  import lcsd_pkg::*;

  lcsd_cmd_t    cmd;
  lcsd_status_t status;

  lcsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  lcsd_dp #(
    .MAX_LINES  (MAX_LINES),
    .TOKEN_BITS (TOKEN_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .line_token_i (line_token_i),
    .out_ready_i  (out_ready_i),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .edit_kind_o  (edit_kind_o),
    .line_index_o (line_index_o),
    .edit_token_o (edit_token_o),
    .overflowed_o (overflowed_o)
  );

endmodule

// ===== rtl/core/lcsd_checker.sv =====
// port checker for the lcs line diff block and its bind
module lcsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  opcode_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  edit_kind_o,
  input logic [7:0]  line_index_o,
  input logic [31:0] edit_token_o,
  input logic        overflowed_o
);
  import lcsd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(edit_kind_o) &&
      $stable(line_index_o) && $stable(edit_token_o) && $stable(overflowed_o))
    else $error("result changed while stalled");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edit_kind_o == KIND_DONE |-> line_index_o == 8'd0 && edit_token_o == 32'd0)
    else $error("done result with nonzero fields");

  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == OP_FETCH |=> !in_ready_o)
    else $error("request taken during fetch");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == OP_COMPUTE |=> !in_ready_o)
    else $error("request taken during table fill");

  a_result_ends_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $rose(in_ready_o))
    else $error("result appeared outside fetch completion");

endmodule

bind lcs_line_diff lcsd_checker u_lcsd_checker (.*);
